// ----- src/mma_pkg.sv -----
// Shared constants, controller/datapath interface types and state encoding for the assembler.
`default_nettype none

package mma_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int FILL_W      = $clog2(STORE_DEPTH + 1);

  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_END   = 8'hF7;
  localparam logic [7:0] RT_MIN      = 8'hF8;

  localparam logic [5:0] MAX_SX_RESET = 6'd63;

  localparam logic [1:0] KIND_RT = 2'd0;
  localparam logic [1:0] KIND_CC = 2'd1;
  localparam logic [1:0] KIND_SX = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROC,
    ST_READ,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic take;
    logic proc;
    logic rd;
    logic load;
  } mma_cmd_t;

  typedef struct packed {
    logic emit;
    logic direct;
    logic at_last;
    logic out_free;
  } mma_sts_t;

endpackage

`default_nettype wire

// ----- src/mma_ctrl.sv -----
// Sequencer: takes one byte, lets the datapath handle it, then walks out the resulting run.
`default_nettype none

module mma_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire mma_pkg::mma_sts_t sts,
  output mma_pkg::mma_cmd_t      cmd
);

  mma_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mma_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      mma_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = mma_pkg::ST_PROC;
        end
      end
      mma_pkg::ST_PROC: begin
        cmd.proc = 1'b1;
        if (!sts.emit) begin
          state_next = mma_pkg::ST_IDLE;
        end else if (sts.direct) begin
          state_next = mma_pkg::ST_LOAD;
        end else begin
          state_next = mma_pkg::ST_READ;
        end
      end
      mma_pkg::ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = mma_pkg::ST_LOAD;
      end
      mma_pkg::ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = sts.at_last ? mma_pkg::ST_IDLE : mma_pkg::ST_READ;
        end
      end
      default: state_next = mma_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/mma_datapath.sv -----
// Datapath: byte decode, message store, counters, limit register and output register.
`default_nettype none

module mma_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mma_pkg::mma_cmd_t cmd,
  output mma_pkg::mma_sts_t      sts,
  input  wire logic [7:0]        in_byte,
  input  wire logic              cfg_wr_en,
  input  wire logic [5:0]        cfg_wr_data,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [7:0]             out_byte,
  output logic                   out_last,
  output logic [1:0]             out_kind,
  output logic [15:0]            out_stray,
  output logic [15:0]            out_abort,
  output logic [15:0]            out_ovf
);

  localparam int AW    = mma_pkg::ADDR_W;
  localparam int FW    = mma_pkg::FILL_W;
  localparam int SW    = FW + 1;
  localparam int DEPTH = mma_pkg::STORE_DEPTH;

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [SW-1:0] n);
    logic [16:0] s;
    s = {1'b0, a} + 17'(n);
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  // standard message length for a status byte, zero where it is stray
  function automatic logic [1:0] msg_length(input logic [7:0] s);
    logic [1:0] len;
    len = 2'd0;
    if (s < 8'hC0) begin
      len = 2'd3;
    end else if (s < 8'hE0) begin
      len = 2'd2;
    end else if (s < 8'hF0) begin
      len = 2'd3;
    end else begin
      unique case (s)
        8'hF1, 8'hF3: len = 2'd2;
        8'hF2:        len = 2'd3;
        8'hF6:        len = 2'd1;
        default:      len = 2'd0;
      endcase
    end
    return len;
  endfunction

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data;
  logic [7:0]    byte_q;
  logic [5:0]    max_sx;
  logic [FW-1:0] fill;
  logic          in_sx;
  logic          ovf;
  logic [1:0]    exp_len;
  logic [15:0]   stray_total;
  logic [15:0]   abort_total;
  logic [15:0]   ovf_total;
  logic          direct_q;
  logic [AW-1:0] last_idx;
  logic [1:0]    kind_q;
  logic [AW-1:0] rd_idx;

  logic [FW-1:0] fill_next;
  logic          in_sx_next;
  logic          ovf_next;
  logic [1:0]    exp_next;
  logic [SW-1:0] stray_add;
  logic          abort_inc;
  logic          ovf_inc;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          emit;
  logic          direct;
  logic [AW-1:0] last_next;
  logic [1:0]    kind_next;
  logic          normal;
  logic [FW-1:0] fill_eff;
  logic [1:0]    len;
  logic [7:0]    fill_p1;
  logic [7:0]    limit;
  logic [AW-1:0] f_cap;

  assign len     = msg_length(byte_q);
  assign fill_p1 = 8'(fill) + 8'd1;
  assign limit   = (8'(max_sx) > 8'(DEPTH - 1)) ? 8'(DEPTH - 1) : 8'(max_sx);
  assign f_cap   = (8'(fill) > 8'(DEPTH - 1)) ? AW'(DEPTH - 1) : fill[AW-1:0];

  always_comb begin
    fill_next  = fill;
    in_sx_next = in_sx;
    ovf_next   = ovf;
    exp_next   = exp_len;
    stray_add  = '0;
    abort_inc  = 1'b0;
    ovf_inc    = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = fill[AW-1:0];
    emit       = 1'b0;
    direct     = 1'b0;
    last_next  = '0;
    kind_next  = mma_pkg::KIND_CC;
    normal     = 1'b0;
    fill_eff   = fill;
    if (byte_q >= mma_pkg::RT_MIN) begin
      emit      = 1'b1;
      direct    = 1'b1;
      kind_next = mma_pkg::KIND_RT;
    end else if (in_sx) begin
      if (byte_q == mma_pkg::SYSEX_END) begin
        if (ovf) begin
          ovf_inc = 1'b1;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = f_cap;
          emit      = 1'b1;
          last_next = f_cap;
          kind_next = mma_pkg::KIND_SX;
        end
        fill_next  = '0;
        in_sx_next = 1'b0;
        ovf_next   = 1'b0;
      end else if (byte_q[7]) begin
        // status inside SysEx: close it out, then decode the status as usual
        if (ovf) begin
          ovf_inc = 1'b1;
        end else begin
          abort_inc = 1'b1;
        end
        fill_next  = '0;
        in_sx_next = 1'b0;
        ovf_next   = 1'b0;
        fill_eff   = '0;
        normal     = 1'b1;
      end else if (!ovf) begin
        if (fill_p1 > limit || 8'(fill) >= 8'(DEPTH)) begin
          ovf_next  = 1'b1;
          fill_next = '0;
        end else begin
          wr_en     = 1'b1;
          fill_next = FW'(fill_p1);
        end
      end
    end else begin
      normal = 1'b1;
    end

    if (normal) begin
      if (byte_q == mma_pkg::SYSEX_START) begin
        stray_add  = SW'(fill_eff);
        wr_en      = 1'b1;
        wr_addr    = '0;
        fill_next  = FW'(1);
        in_sx_next = 1'b1;
        ovf_next   = 1'b0;
        exp_next   = 2'd0;
      end else if (byte_q[7]) begin
        stray_add = SW'(fill_eff) + SW'(len == 2'd0);
        exp_next  = len;
        fill_next = '0;
        if (len != 2'd0) begin
          wr_en     = 1'b1;
          wr_addr   = '0;
          fill_next = FW'(1);
        end
        if (len == 2'd1) begin
          fill_next = '0;
          exp_next  = 2'd0;
          emit      = 1'b1;
          direct    = 1'b1;
        end
      end else if (fill == '0 || 8'(fill) >= 8'd3) begin
        stray_add = SW'(1);
      end else begin
        wr_en     = 1'b1;
        fill_next = FW'(fill_p1);
        if (fill_p1 == 8'(exp_len)) begin
          emit      = 1'b1;
          last_next = fill[AW-1:0];
          fill_next = '0;
          exp_next  = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.proc && wr_en) begin
      mem[wr_addr] <= byte_q;
    end
    if (cmd.rd) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      byte_q <= in_byte;
    end
    if (cmd.proc) begin
      direct_q <= direct;
      last_idx <= last_next;
      kind_q   <= kind_next;
    end
    if (cmd.load) begin
      out_byte  <= direct_q ? byte_q : rd_data;
      out_last  <= (rd_idx == last_idx);
      out_kind  <= kind_q;
      out_stray <= stray_total;
      out_abort <= abort_total;
      out_ovf   <= ovf_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_sx      <= mma_pkg::MAX_SX_RESET;
      fill        <= '0;
      in_sx       <= 1'b0;
      ovf         <= 1'b0;
      exp_len     <= 2'd0;
      stray_total <= '0;
      abort_total <= '0;
      ovf_total   <= '0;
      rd_idx      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_sx <= cfg_wr_data;
      end
      if (cmd.proc) begin
        fill        <= fill_next;
        in_sx       <= in_sx_next;
        ovf         <= ovf_next;
        exp_len     <= exp_next;
        stray_total <= sat_add(stray_total, stray_add);
        abort_total <= sat_add(abort_total, SW'(abort_inc));
        ovf_total   <= sat_add(ovf_total, SW'(ovf_inc));
        rd_idx      <= '0;
      end else if (cmd.load) begin
        rd_idx <= rd_idx + AW'(1);
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.emit     = emit;
  assign sts.direct   = direct;
  assign sts.at_last  = (rd_idx == last_idx);
  assign sts.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// ----- src/midi_message_assembler.sv -----
// Top level of the MIDI message assembler: sequencer plus datapath.
//
//  channel  | group           | contents
//  ---------+-----------------+-----------------------------------------------------------
//  input    | s_axis_*        | tdata = byte_in
//  output   | m_axis_*        | tdata = out_byte, counters; tlast = is_last; tuser = kind
//  config   | cfg_wr_*        | max_sysex_bytes, written on cfg_wr_en
//
// One byte at a time: accept, decode, then for each emitted byte a store read and an
// output load, the load waiting while the output register is full. A byte with no
// output goes back to accept; a realtime or one-byte message loads the held byte directly.
// A finished last byte may wait in the output register while the next byte is taken.
// rst is synchronous; store contents are not cleared, no clearing pass is needed.
`default_nettype none

module midi_message_assembler (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // [7:0] out_byte, [23:8] stray_count,
                                           // [39:24] aborted_count, [55:40] overflow_count
  output logic             m_axis_tlast,
  output logic [1:0]       m_axis_tuser,   // [1:0] msg_kind
  input  wire logic        cfg_wr_en,
  input  wire logic [5:0]  cfg_wr_data
);

  mma_pkg::mma_cmd_t cmd;
  mma_pkg::mma_sts_t sts;
  logic [7:0]        out_byte;
  logic [15:0]       out_stray;
  logic [15:0]       out_abort;
  logic [15:0]       out_ovf;

  mma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mma_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_byte     (s_axis_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_byte    (out_byte),
    .out_last    (m_axis_tlast),
    .out_kind    (m_axis_tuser),
    .out_stray   (out_stray),
    .out_abort   (out_abort),
    .out_ovf     (out_ovf)
  );

  assign m_axis_tdata = {out_ovf, out_abort, out_stray, out_byte};

endmodule

`default_nettype wire

// ----- src/mma_checker.sv -----
// Port-level checks on the assembler, bound to the top level.
`default_nettype none

module mma_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [55:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic [1:0]  m_axis_tuser
);

  // a request held off must stay offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output request dropped while stalled");

  // one byte at a time: busy in the cycle after a request is taken
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken back to back");

  // realtime messages are a single byte
  a_rt_single: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == mma_pkg::KIND_RT |-> m_axis_tlast)
    else $error("realtime message longer than one byte");

  // counters only grow between successive offered results
  a_cnt_mono: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && $past(m_axis_tvalid) && !$past(rst) |->
      m_axis_tdata[23:8] >= $past(m_axis_tdata[23:8]) &&
      m_axis_tdata[39:24] >= $past(m_axis_tdata[39:24]) &&
      m_axis_tdata[55:40] >= $past(m_axis_tdata[55:40]))
    else $error("error counter went backwards");

endmodule

bind midi_message_assembler mma_checker u_mma_checker (.*);

`default_nettype wire
